>>> hw/rtl/bpa_pkg.sv
// Shared constants, codes and bit-vector helpers of the bitmap page allocator.
package bpa_pkg;

  localparam int ADDR_W      = 48;
  localparam int COUNT_W     = 15;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int PAGE_SHIFT  = 12;
  localparam int WORD_BITS   = 64;
  localparam int PAGE_COUNT_DEF = 16384;
  localparam int MAX_RUN_DEF    = 64;
  localparam logic [ADDR_W-1:0] REGION_BASE_RST = 48'h0000_0010_0000;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  // Bit j of the result is set when a run of cnt free pages ends at window bit 64+j.
  function automatic word_t run_end(input logic [127:0] fr, input logic [6:0] cnt);
    logic [127:0] acc;
    logic [127:0] blk;
    acc = '1;
    blk = fr;
    for (int k = 0; k < 7; k++) begin
      if (cnt[k]) begin
        acc = (acc << (1 << k)) & blk;
      end
      blk = blk & (blk << (1 << k));
    end
    return acc[127:64];
  endfunction

  function automatic logic [5:0] lowest_set(input word_t v);
    logic [5:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic [6:0] pop_count(input word_t v);
    logic [6:0] sum;
    sum = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      sum = sum + 7'(v[i]);
    end
    return sum;
  endfunction

endpackage

>>> hw/rtl/bpa_ifs.sv
// Channel interfaces of the bitmap page allocator: request, response, configuration.
interface bpa_req_if;
  logic                                valid;
  logic                                ready;
  logic [bpa_pkg::OP_W-1:0]            op;
  logic [bpa_pkg::COUNT_W-1:0]         page_count;
  logic [bpa_pkg::ADDR_W-1:0]          address;
  modport source (output valid, op, page_count, address, input ready);
  modport sink   (input valid, op, page_count, address, output ready);
endinterface

interface bpa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bpa_pkg::ADDR_W-1:0]          granted_address;
  logic [bpa_pkg::STATUS_W-1:0]        status;
  logic [bpa_pkg::COUNT_W-1:0]         free_pages;
  modport source (output valid, granted_address, status, free_pages, input ready);
  modport sink   (input valid, granted_address, status, free_pages, output ready);
endinterface

interface bpa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bpa_pkg::ADDR_W-1:0]          data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/bitmap_page_allocator_core.sv
// First-fit bitmap page allocator: one used bit per 4 KiB page held in a word memory.
//
// The used bits live in a synchronous memory of 64-bit words, (PAGE_COUNT+63)/64 deep,
// with one registered read port and one write port. After reset the block
// runs a clearing pass of one word a cycle, during which no request beat is taken;
// configuration beats are taken at any time.
// An allocate streams the memory one word a cycle from word 0 and looks for the run in a
// 128-bit window of the previous and current word, then writes the run into one or two
// words. Free and reserve first clip their range to the span, then visit only the words
// the clipped range covers, reading each word and then modifying and writing it back.
// One request is in flight at a time; a new request beat is taken while the last
// response still waits in the output register.
module bitmap_page_allocator_core #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int MAX_RUN    = bpa_pkg::MAX_RUN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  bpa_req_if.sink      req,
  bpa_rsp_if.source    rsp,
  bpa_cfg_if.sink      cfg
);

  localparam int WORDS = (PAGE_COUNT + 63) / 64;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(PAGE_COUNT + 1);
  localparam int SW    = AW + 6;
  localparam int TAIL  = PAGE_COUNT % 64;
  localparam bpa_pkg::word_t TAIL_MASK =
    (TAIL == 0) ? '1 : ((bpa_pkg::word_t'(1) << TAIL) - bpa_pkg::word_t'(1));
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_MARK1 = 4'd3;
  localparam logic [3:0] S_MARK0 = 4'd4;
  localparam logic [3:0] S_RSET  = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RMOD  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Bitmap memory.
  bpa_pkg::word_t mem [WORDS];
  bpa_pkg::word_t rdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  bpa_pkg::word_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Control and working registers.
  logic [3:0]                     state;
  logic [AW-1:0]                  clr_cnt;
  logic [bpa_pkg::ADDR_W-1:0]     region_base;
  logic [PW-1:0]                  free_cnt;
  logic [6:0]                     run_cnt;
  logic [AW:0]                    sc_rd;
  logic                           dv;
  logic [AW-1:0]                  sc_w;
  bpa_pkg::word_t                 prev_free;
  bpa_pkg::word_t                 prev_used;
  bpa_pkg::word_t                 hit_cur;
  bpa_pkg::word_t                 hit_prev;
  logic [AW-1:0]                  hit_word;
  logic [5:0]                     hit_bit;
  logic                           is_free;
  logic [35:0]                    rng_first;
  logic [36:0]                    rng_last;
  logic [SW-1:0]                  lo;
  logic [SW-1:0]                  hi1;
  logic [AW-1:0]                  rw;
  logic [bpa_pkg::ADDR_W-1:0]     res_addr;
  logic [bpa_pkg::STATUS_W-1:0]   res_status;
  logic                           out_valid;
  logic [bpa_pkg::ADDR_W-1:0]     out_addr;
  logic [bpa_pkg::STATUS_W-1:0]   out_status;
  logic [bpa_pkg::COUNT_W-1:0]    out_free;

  // Request decode, done in the accept cycle.
  logic [bpa_pkg::ADDR_W-1:0] off_up;
  logic [bpa_pkg::ADDR_W-1:0] off_dn;
  logic                       addr_below;
  logic [35:0]                below_pg;
  logic [36:0]                rsv_last;

  assign off_up     = req.address - region_base;
  assign off_dn     = region_base - req.address;
  assign addr_below = req.address < region_base;
  assign below_pg   = off_dn[47:12];
  assign rsv_last   = (below_pg >= 36'(req.page_count)) ? '0
                    : 37'(36'(req.page_count) - below_pg);

  // Scan window: previous word's free bits below, current word above.
  bpa_pkg::word_t cur_free;
  bpa_pkg::word_t hits;
  assign cur_free = ~rdata & ((sc_w == LAST_WORD) ? TAIL_MASK : '1);
  assign hits     = bpa_pkg::run_end({cur_free, prev_free}, run_cnt);

  // Mark mask of the found run across the two words.
  logic [7:0]   mk_sh;
  logic [127:0] mk_mask;
  logic [SW-1:0] start_pg;
  assign mk_sh    = 8'd65 + {2'b00, hit_bit} - {1'b0, run_cnt};
  assign mk_mask  = ((128'(1) << run_cnt) - 128'(1)) << mk_sh;
  assign start_pg = {hit_word, hit_bit} - SW'(run_cnt) + SW'(1);

  // Range modify of one word.
  logic [AW-1:0]   lo_w;
  logic [AW-1:0]   hi_w;
  logic [5:0]      lb;
  logic [5:0]      hb;
  bpa_pkg::word_t  rmask;
  bpa_pkg::word_t  rnew;
  logic [6:0]      rdelta;
  assign lo_w   = lo[SW-1:6];
  assign hi_w   = hi1[SW-1:6];
  assign lb     = (rw == lo_w) ? lo[5:0] : 6'd0;
  assign hb     = (rw == hi_w) ? hi1[5:0] : 6'd63;
  assign rmask  = ({64{1'b1}} << lb) & ({64{1'b1}} >> (6'd63 - hb));
  assign rnew   = is_free ? (rdata & ~rmask) : (rdata | rmask);
  assign rdelta = bpa_pkg::pop_count(rdata ^ rnew);

  logic [36:0] last_clip;
  assign last_clip = (rng_last > 37'(PAGE_COUNT)) ? 37'(PAGE_COUNT) : rng_last;

  logic slot_free;
  assign slot_free = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid           = out_valid;
  assign rsp.granted_address = out_addr;
  assign rsp.status          = out_status;
  assign rsp.free_pages      = out_free;

  // Memory port steering.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = sc_rd[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_re = (sc_rd < (AW+1)'(WORDS));
      end
      S_MARK1: begin
        mem_we    = 1'b1;
        mem_waddr = hit_word;
        mem_wdata = hit_cur | mk_mask[127:64];
      end
      S_MARK0: begin
        mem_we    = 1'b1;
        mem_waddr = hit_word - AW'(1);
        mem_wdata = hit_prev | mk_mask[63:0];
      end
      S_RRD: begin
        mem_re    = 1'b1;
        mem_raddr = rw;
      end
      S_RMOD: begin
        mem_we    = 1'b1;
        mem_waddr = rw;
        mem_wdata = rnew;
      end
      default: begin
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= bpa_pkg::REGION_BASE_RST;
    end else if (cfg.valid) begin
      region_base <= cfg.data;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      free_cnt  <= PW'(PAGE_COUNT);
      out_valid <= 1'b0;
      dv        <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            res_addr   <= '0;
            res_status <= bpa_pkg::ST_OK;
            run_cnt    <= 7'(req.page_count);
            state      <= S_DONE;
            case (req.op)
              bpa_pkg::OP_ALLOC: begin
                if (req.page_count == '0 || req.page_count > bpa_pkg::COUNT_W'(MAX_RUN)) begin
                  res_status <= bpa_pkg::ST_BAD_COUNT;
                end else begin
                  sc_rd     <= '0;
                  dv        <= 1'b0;
                  prev_free <= '0;
                  prev_used <= '0;
                  state     <= S_SCAN;
                end
              end
              bpa_pkg::OP_FREE: begin
                if (addr_below || off_up[11:0] != 12'd0) begin
                  res_status <= bpa_pkg::ST_BAD_ADDR;
                end else begin
                  is_free   <= 1'b1;
                  rng_first <= off_up[47:12];
                  rng_last  <= 37'(off_up[47:12]) + 37'(req.page_count);
                  state     <= S_RSET;
                end
              end
              bpa_pkg::OP_RESERVE: begin
                if ((req.address[11:0] ^ region_base[11:0]) != 12'd0) begin
                  res_status <= bpa_pkg::ST_BAD_ADDR;
                end else begin
                  is_free <= 1'b0;
                  state   <= S_RSET;
                  if (!addr_below) begin
                    rng_first <= off_up[47:12];
                    rng_last  <= 37'(off_up[47:12]) + 37'(req.page_count);
                  end else begin
                    rng_first <= '0;
                    rng_last  <= rsv_last;
                  end
                end
              end
              default: begin
                res_status <= bpa_pkg::ST_BAD_ADDR;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue the next read and check the word that came back.
          if (sc_rd < (AW+1)'(WORDS)) begin
            sc_rd <= sc_rd + (AW+1)'(1);
            sc_w  <= sc_rd[AW-1:0];
            dv    <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            prev_free <= cur_free;
            prev_used <= rdata;
            if (hits != '0) begin
              hit_word <= sc_w;
              hit_bit  <= bpa_pkg::lowest_set(hits);
              hit_cur  <= rdata;
              hit_prev <= prev_used;
              dv       <= 1'b0;
              state    <= S_MARK1;
            end else if (sc_w == LAST_WORD) begin
              res_status <= bpa_pkg::ST_NO_ROOM;
              dv         <= 1'b0;
              state      <= S_DONE;
            end
          end
        end
        S_MARK1: begin
          free_cnt <= free_cnt - PW'(run_cnt);
          res_addr <= bpa_pkg::ADDR_W'(region_base
                      + (bpa_pkg::ADDR_W'(start_pg) << bpa_pkg::PAGE_SHIFT));
          state    <= (mk_mask[63:0] != '0) ? S_MARK0 : S_DONE;
        end
        S_MARK0: begin
          state <= S_DONE;
        end
        S_RSET: begin
          // Clip to the span; drop empty ranges.
          if (37'(rng_first) >= last_clip) begin
            state <= S_DONE;
          end else begin
            lo    <= SW'(rng_first);
            hi1   <= SW'(last_clip - 37'(1));
            rw    <= rng_first[SW-1:6];
            state <= S_RRD;
          end
        end
        S_RRD: begin
          state <= S_RMOD;
        end
        S_RMOD: begin
          free_cnt <= is_free ? free_cnt + PW'(rdelta) : free_cnt - PW'(rdelta);
          if (rw == hi_w) begin
            state <= S_DONE;
          end else begin
            rw    <= rw + AW'(1);
            state <= S_RRD;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            out_free   <= bpa_pkg::COUNT_W'(free_cnt);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> bench/bpa_checker.sv
// Response checker for the bitmap page allocator: tracks the page map and compares each beat.
`timescale 1ns / 100ps
module bpa_checker (
  input  logic clk,
  input  logic rst,
  bpa_req_if   req,
  bpa_rsp_if   rsp,
  bpa_cfg_if   cfg,
  output int   errors,
  output int   pending,
  output int   checked
);
  import bpa_pkg::*;

  localparam int PAGES = PAGE_COUNT_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_pages;
  } grant_t;

  bit                used_pages [PAGES];
  int                free_total;
  logic [ADDR_W-1:0] base_addr;
  grant_t            grant_q [$];

  function automatic void take_page(longint unsigned pg);
    if (pg < PAGES && !used_pages[pg]) begin
      used_pages[pg] = 1'b1;
      free_total--;
    end
  endfunction

  function automatic void give_page(longint unsigned pg);
    if (pg < PAGES && used_pages[pg]) begin
      used_pages[pg] = 1'b0;
      free_total++;
    end
  endfunction

  function automatic grant_t serve_request(logic [OP_W-1:0] op, logic [COUNT_W-1:0] cnt,
                                           logic [ADDR_W-1:0] addr);
    grant_t          g;
    longint unsigned run, start, first, last, below;
    logic [ADDR_W-1:0] off;
    bit              found;
    g = '0;
    g.status = ST_OK;
    run = 0;
    start = 0;
    found = 0;
    if (op == OP_ALLOC) begin
      if (cnt == 0 || cnt > MAX_RUN_DEF) begin
        g.status = ST_BAD_COUNT;
      end else begin
        for (int i = 0; i < PAGES; i++) begin
          if (!used_pages[i]) begin
            if (run == 0) start = i;
            run++;
            if (run == cnt) begin
              found = 1;
              break;
            end
          end else begin
            run = 0;
          end
        end
        if (found) begin
          for (longint unsigned i = start; i < start + cnt; i++) take_page(i);
          g.granted = base_addr + (ADDR_W'(start) << PAGE_SHIFT);
        end else begin
          g.status = ST_NO_ROOM;
        end
      end
    end else if (op == OP_FREE) begin
      off = addr - base_addr;
      if (addr < base_addr || off[PAGE_SHIFT-1:0] != 0) begin
        g.status = ST_BAD_ADDR;
      end else begin
        first = off >> PAGE_SHIFT;
        for (longint unsigned i = 0; i < cnt; i++) begin
          if (first + i >= PAGES) break;
          give_page(first + i);
        end
      end
    end else if (op == OP_RESERVE) begin
      if (addr[PAGE_SHIFT-1:0] != base_addr[PAGE_SHIFT-1:0]) begin
        g.status = ST_BAD_ADDR;
      end else begin
        if (addr >= base_addr) begin
          first = (addr - base_addr) >> PAGE_SHIFT;
          last = first + cnt;
        end else begin
          below = (base_addr - addr) >> PAGE_SHIFT;
          first = 0;
          last = (below >= cnt) ? 0 : cnt - below;
        end
        if (last > PAGES) last = PAGES;
        for (longint unsigned i = first; i < last; i++) take_page(i);
      end
    end else begin
      g.status = ST_BAD_ADDR;
    end
    g.free_pages = COUNT_W'(free_total);
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      foreach (used_pages[i]) used_pages[i] = 1'b0;
      free_total = PAGES;
      base_addr = REGION_BASE_RST;
      grant_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg.valid && cfg.ready) base_addr = cfg.data;
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: response beat with nothing expected: addr %h status %0d free %0d",
                   $time, rsp.granted_address, rsp.status, rsp.free_pages);
          errors++;
        end else begin
          want = grant_q.pop_front();
          checked++;
          if (rsp.granted_address !== want.granted) begin
            $display("%0t: granted_address expected %h actual %h",
                     $time, want.granted, rsp.granted_address);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            errors++;
          end
          if (rsp.free_pages !== want.free_pages) begin
            $display("%0t: free_pages expected %0d actual %0d",
                     $time, want.free_pages, rsp.free_pages);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        grant_q.push_back(serve_request(req.op, req.page_count, req.address));
    end
    pending = grant_q.size();
  end

endmodule

>>> bench/bitmap_page_allocator_core_tb.sv
// Testbench top for the bitmap page allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module bitmap_page_allocator_core_tb;
  import bpa_pkg::*;

  // Op code the block does not implement.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  logic clk;
  logic rst;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();
  bpa_cfg_if cfg_ch ();

  int errors;
  int pending;
  int checked;
  int sent;
  int bases_used;

  // Sender raises this to make the response side hold off for a long stretch.
  bit long_hold;
  // Set for the tail of the run: no idling on either side.
  bit calm;

  logic [ADDR_W-1:0] cur_base;

  bitmap_page_allocator_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  bpa_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (clearing pass, full-span scans, stalls).
  initial begin
    #10ms;
    $display("bitmap_page_allocator_core test failed");
    $finish;
  end

  // Response side: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (299) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request beat and hold it until the block takes it.
  // Called on a clock edge; a random gap may drop valid first.
  task automatic send(logic [OP_W-1:0] op, logic [COUNT_W-1:0] cnt, logic [ADDR_W-1:0] addr);
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.page_count <= cnt;
    req_ch.address    <= addr;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Drop valid and wait until every outstanding response beat has been checked.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(logic [ADDR_W-1:0] b);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= b;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cur_base = b;
    bases_used++;
  endtask

  function automatic logic [ADDR_W-1:0] page_addr(int pg);
    return cur_base + (ADDR_W'(pg) << PAGE_SHIFT);
  endfunction

  // Pick a page index: mostly near the bottom where first fit packs runs.
  function automatic int pick_page();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16500) : $urandom_range(0, 1200);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return COUNT_W'($urandom_range(1, 64));
    if (r < 95) return COUNT_W'($urandom_range(65, 2000));
    return COUNT_W'($urandom_range(0, 16384));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // Allocate: mostly legal run lengths, some out-of-range counts.
      if ($urandom_range(0, 9) != 0) send(OP_ALLOC, COUNT_W'($urandom_range(1, 64)), '0);
      else send(OP_ALLOC, COUNT_W'($urandom), ADDR_W'({$urandom, $urandom}));
    end else if (r < 75) begin
      if ($urandom_range(0, 11) == 0)
        send(OP_FREE, COUNT_W'($urandom), ADDR_W'({$urandom, $urandom}));
      else if ($urandom_range(0, 49) == 0)
        send(OP_FREE, COUNT_W'(16384), cur_base);
      else
        send(OP_FREE, pick_count(), page_addr(pick_page()));
    end else if (r < 95) begin
      if ($urandom_range(0, 11) == 0)
        send(OP_RESERVE, COUNT_W'($urandom), ADDR_W'({$urandom, $urandom}));
      else if ($urandom_range(0, 9) == 0)
        send(OP_RESERVE, pick_count(), cur_base - (ADDR_W'($urandom_range(0, 80)) << PAGE_SHIFT));
      else
        send(OP_RESERVE, COUNT_W'($urandom_range(0, 64)), page_addr(pick_page()));
    end else begin
      send(OP_UNKNOWN, COUNT_W'($urandom), ADDR_W'({$urandom, $urandom}));
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] phase_base [4];
    sent = 0;
    bases_used = 0;
    long_hold = 0;
    calm = 0;
    cur_base = REGION_BASE_RST;
    phase_base[0] = '0;
    phase_base[1] = 48'hFFFF_FFFF_F000;
    phase_base[2] = 48'h1234_5678_9ABC;
    phase_base[3] = REGION_BASE_RST;

    // Drive every input known from time zero and hold reset.
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_ALLOC;
    req_ch.page_count  <= '0;
    req_ch.address     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset base; the clearing pass just delays the first beat.
    send(OP_ALLOC, 1, '0);
    send(OP_ALLOC, 64, '0);
    send(OP_ALLOC, 0, '0);
    send(OP_ALLOC, 65, '0);
    send(OP_ALLOC, 15'h7FFF, 48'hFFFF_FFFF_FFFF);
    send(OP_FREE, 4, cur_base + 48'h800);
    send(OP_FREE, 4, cur_base - 48'h1000);
    send(OP_FREE, 1, cur_base + 48'h1000);
    send(OP_FREE, 0, cur_base);
    send(OP_RESERVE, 100, page_addr(16330));
    send(OP_FREE, 100, page_addr(16340));
    send(OP_RESERVE, 8, cur_base + 48'h10);
    send(OP_RESERVE, 10, cur_base - 48'h4000);
    send(OP_RESERVE, 2, cur_base - 48'h8000);
    send(OP_RESERVE, 0, page_addr(10));
    send(OP_UNKNOWN, 1, cur_base);
    // Fill the whole span, see both allocate failures, then empty it again.
    send(OP_RESERVE, 15'd16384, cur_base);
    send(OP_ALLOC, 1, '0);
    send(OP_FREE, 3, page_addr(200));
    send(OP_ALLOC, 4, '0);
    send(OP_ALLOC, 3, '0);
    send(OP_FREE, 15'd16384, cur_base);
    send(OP_ALLOC, 64, '0);

    // Random phases, one per base setting, extremes among them.
    for (int p = 0; p < 4; p++) begin
      set_base(phase_base[p]);
      // The top base makes every grant past page 0 wrap the 48-bit address.
      if (p == 1) send(OP_ALLOC, 64, '0);
      for (int n = 0; n < 400; n++) begin
        if (p == 3 && n == 200) calm = 1;
        if (p == 0 && n == 100) long_hold = 1;
        if (n == 250) drain();
        random_item();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d request beats over %0d base settings (reset, zero, top, unaligned).",
             sent, bases_used + 1);
    $display("Checked %0d response beats, %0d mismatches, %0d left waiting.",
             checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("bitmap_page_allocator_core test passed");
    end else begin
      $display("bitmap_page_allocator_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ifs.sv
hw/rtl/bitmap_page_allocator_core.sv
bench/bpa_checker.sv
bench/bitmap_page_allocator_core_tb.sv
